[rtl/core/ped_pkg.sv]
// Shared types, constants and helper functions of the percent-escape decoder.
package ped_pkg;

  // Reset value of the capacity register and the escape introducer.
  localparam logic [15:0] CAPACITY_RESET = 16'd256;
  localparam logic [7:0]  PERCENT_CHAR   = 8'h25;

  // Status codes reported on the final result of a string.
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_CUT = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  // Escape phase, one-hot.
  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_FIRST  = 3'b010,
    PH_SECOND = 3'b100
  } phase_t;

  // Decoded value of one hex character.
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // One result item as it travels from the decoder to the result register.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       done_res;
    logic [1:0] status;
  } res_t;

  // Converts an ASCII character to its hex digit value, either case.
  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t       h;
    logic [7:0] d;
    h.ok  = 1'b0;
    h.val = 4'd0;
    d     = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d     = c - 8'h30;
      h.ok  = 1'b1;
      h.val = d[3:0];
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d     = c - 8'h37;
      h.ok  = 1'b1;
      h.val = d[3:0];
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d     = c - 8'h57;
      h.ok  = 1'b1;
      h.val = d[3:0];
    end
    return h;
  endfunction

endpackage

[rtl/core/ped_in_reg.sv]
// Input register of the percent-escape decoder.
module ped_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] byte_in,
  input  logic       last_in,
  input  logic       advance,
  output logic       a_valid,
  output logic [7:0] a_byte,
  output logic       a_last
);

  logic a_valid_next;

  // The register takes a new transfer when it is empty or its item moves on.
  assign in_ready = !a_valid || advance;

  always_comb begin
    a_valid_next = a_valid;
    if (in_valid && in_ready) begin
      a_valid_next = 1'b1;
    end else if (advance) begin
      a_valid_next = 1'b0;
    end
  end

  // Control bit with reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= a_valid_next;
    end
  end

  // Payload holds without reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_byte <= byte_in;
      a_last <= last_in;
    end
  end

endmodule

[rtl/core/ped_decode.sv]
// String state, capacity register and per-byte decode logic.
module ped_decode (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_wr_en,
  input  logic [15:0]    cfg_wr_data,
  input  logic           step,
  input  logic [7:0]     a_byte,
  input  logic           a_last,
  output logic           has_res,
  output ped_pkg::res_t  res
);

  logic [15:0]     capacity;
  ped_pkg::phase_t phase, phase_next;
  logic [3:0]      high_nibble, high_nibble_next;
  logic            bad_digit_seen, bad_digit_seen_next;
  logic [15:0]     emitted_count, emitted_count_next;
  logic            halted, halted_next;
  logic [1:0]      error_code, error_code_next;

  logic [15:0]     limit;
  logic            full;
  logic            emit;
  logic [7:0]      val;
  ped_pkg::hex_t   hx;

  // Byte limit is capacity minus one, with capacity zero acting as one.
  assign limit = (capacity == 16'd0) ? 16'd0 : capacity - 16'd1;
  assign full  = emitted_count >= limit;
  assign hx    = ped_pkg::hex_value(a_byte);

  // Next string state and result for the byte in the input register.
  always_comb begin
    phase_next          = phase;
    high_nibble_next    = high_nibble;
    bad_digit_seen_next = bad_digit_seen;
    halted_next         = halted;
    error_code_next     = error_code;
    emit                = 1'b0;
    val                 = 8'd0;
    if (!halted) begin
      unique case (phase)
        ped_pkg::PH_FIRST: begin
          if (!hx.ok) begin
            bad_digit_seen_next = 1'b1;
            high_nibble_next    = 4'd0;
          end else begin
            high_nibble_next = hx.val;
          end
          phase_next = ped_pkg::PH_SECOND;
        end
        ped_pkg::PH_SECOND: begin
          phase_next = ped_pkg::PH_IDLE;
          if (bad_digit_seen || !hx.ok) begin
            halted_next     = 1'b1;
            error_code_next = ped_pkg::ST_BAD;
          end else if (full) begin
            halted_next = 1'b1;
          end else begin
            emit = 1'b1;
            val  = {high_nibble, hx.val};
          end
          bad_digit_seen_next = 1'b0;
        end
        default: begin
          phase_next = ped_pkg::PH_IDLE;
          if (a_byte == ped_pkg::PERCENT_CHAR) begin
            phase_next = ped_pkg::PH_FIRST;
          end else if (full) begin
            halted_next = 1'b1;
          end else begin
            emit = 1'b1;
            val  = a_byte;
          end
        end
      endcase
    end
    emitted_count_next = emit ? emitted_count + 16'd1 : emitted_count;

    // Result fields; status only on the final byte of a string.
    has_res       = emit || a_last;
    res.out_byte  = val;
    res.out_valid = emit;
    res.done_res  = a_last;
    res.status    = ped_pkg::ST_OK;
    if (a_last) begin
      if (halted_next) begin
        res.status = error_code_next;
      end else if (phase_next != ped_pkg::PH_IDLE) begin
        res.status = ped_pkg::ST_CUT;
      end
      // The end of a string clears all string state.
      phase_next          = ped_pkg::PH_IDLE;
      high_nibble_next    = 4'd0;
      bad_digit_seen_next = 1'b0;
      emitted_count_next  = 16'd0;
      halted_next         = 1'b0;
      error_code_next     = ped_pkg::ST_OK;
    end
  end

  // Capacity register, written directly from the configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= ped_pkg::CAPACITY_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  // String state advances once per byte that leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= ped_pkg::PH_IDLE;
      high_nibble    <= 4'd0;
      bad_digit_seen <= 1'b0;
      emitted_count  <= 16'd0;
      halted         <= 1'b0;
      error_code     <= ped_pkg::ST_OK;
    end else if (step) begin
      phase          <= phase_next;
      high_nibble    <= high_nibble_next;
      bad_digit_seen <= bad_digit_seen_next;
      emitted_count  <= emitted_count_next;
      halted         <= halted_next;
      error_code     <= error_code_next;
    end
  end

endmodule

[rtl/core/ped_out_reg.sv]
// Result register of the percent-escape decoder.
module ped_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  ped_pkg::res_t res,
  output logic          b_free,
  output logic          res_valid,
  input  logic          res_ready,
  output logic [7:0]    out_byte,
  output logic          out_valid,
  output logic          done_res,
  output logic [1:0]    status
);

  logic          b_valid, b_valid_next;
  ped_pkg::res_t b_res;

  // The register can take a result when empty or when its result leaves now.
  assign b_free = !b_valid || res_ready;

  always_comb begin
    b_valid_next = b_valid;
    if (load) begin
      b_valid_next = 1'b1;
    end else if (res_ready) begin
      b_valid_next = 1'b0;
    end
  end

  // Control bit with reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= b_valid_next;
    end
  end

  // Payload holds without reset.
  always_ff @(posedge clk) begin
    if (load) begin
      b_res <= res;
    end
  end

  assign res_valid = b_valid;
  assign out_byte  = b_res.out_byte;
  assign out_valid = b_res.out_valid;
  assign done_res  = b_res.done_res;
  assign status    = b_res.status;

endmodule

[rtl/core/percent_escape_decoder_top.sv]
// Top level of the streaming percent-escape decoder.
//
// Input channel: in_valid/in_ready carry byte_in and last_in, one character
// of an encoded string per transfer, last_in marking the final character.
// Result channel: res_valid/res_ready carry out_byte, out_valid, done_res
// and status. A result is produced for every emitted byte and for every
// final character; other characters produce none.
// Configuration: cfg_wr_en/cfg_wr_data write the capacity register at once;
// write it only while no string bytes are in flight.
// Path: an accepted character reaches the result channel through an input
// register and a result register.
// Throughput: one character per cycle while the result channel does not
// stall, set by the combinational decode between the two registers.
// Reset: rst is synchronous; both registers empty, string state cleared,
// capacity back to 256.
// Stall: while res_ready is low the result holds and no character is
// decoded; the input register takes at most one more character and then
// drops in_ready.
module percent_escape_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_in,
  input  logic        last_in,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [7:0]  out_byte,
  output logic        out_valid,
  output logic        done_res,
  output logic [1:0]  status
);

  logic          a_valid;
  logic [7:0]    a_byte;
  logic          a_last;
  logic          advance;
  logic          has_res;
  logic          b_free;
  ped_pkg::res_t res;

  // A character moves on when the result register has room for its result.
  assign advance = a_valid && b_free;

  ped_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .byte_in  (byte_in),
    .last_in  (last_in),
    .advance  (advance),
    .a_valid  (a_valid),
    .a_byte   (a_byte),
    .a_last   (a_last)
  );

  ped_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (advance),
    .a_byte      (a_byte),
    .a_last      (a_last),
    .has_res     (has_res),
    .res         (res)
  );

  ped_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && has_res),
    .res       (res),
    .b_free    (b_free),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .out_byte  (out_byte),
    .out_valid (out_valid),
    .done_res  (done_res),
    .status    (status)
  );

`ifndef ASSERT_OFF
  // Every result carries a byte or closes a string.
  a_res_nonempty: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (out_valid || done_res))
    else $error("result with neither byte nor end of string");

  // Status is zero except on the final result of a string.
  a_status_only_done: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !done_res) |-> (status == ped_pkg::ST_OK))
    else $error("status set on a result that does not close a string");

  // The byte field is zero when it carries no byte.
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !out_valid) |-> (out_byte == 8'd0))
    else $error("out_byte nonzero without out_valid");

  // A stalled result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |-> !(advance && has_res))
    else $error("result register loaded while stalled");
`endif

endmodule
